// ===== sv/rating_tally_ranker_macros.svh =====
// ----------------------------------------------------------------------------
// rating_tally_ranker assertion macros
// Shared macros for the concurrent assertions of the rating tally ranker.
// ----------------------------------------------------------------------------
`ifndef RATING_TALLY_RANKER_MACROS_SVH
`define RATING_TALLY_RANKER_MACROS_SVH

// Checked on every rising edge outside of reset.
`define RTR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RTR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/rtr_pkg.sv =====
// ----------------------------------------------------------------------------
// rtr_pkg
// Request and result types and fixed constants of the rating tally ranker.
// ----------------------------------------------------------------------------
package rtr_pkg;

    localparam int TOTAL_W = 40;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
    localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

    typedef struct packed {
        logic               cmd;
        logic [4:0]         candidate;
        logic signed [15:0] rating;
        logic               rating_absent;
        logic               last_of_ballot;
    } t_in;

    typedef struct packed {
        logic [4:0]                ranked_candidate;
        logic signed [TOTAL_W-1:0] total;
        logic [31:0]               ballots;
        logic                      last_result;
    } t_out;

endpackage

// ===== sv/rating_tally_ranker.sv =====
// ----------------------------------------------------------------------------
// rating_tally_ranker
// Saturating per-candidate rating totals with a ranked report readout.
// ----------------------------------------------------------------------------
// An add request (cmd 0) reads the candidate's total from the totals memory
// in the accept cycle, and the saturated sum is written back in the next
// cycle, during which o_ready is low. Absent ratings and out-of-range
// candidates complete in the accept cycle with no write-back. A report
// request (cmd 1) ranks the N used candidates by a repeated selection scan
// through one shared comparator: each rank scans all N entries, reading each
// from memory and then comparing it, and then loads the output register.
// That load waits while the consumer stalls the result channel.
// Results leave in descending total order with ties in ascending index order.
// The totals read as zero after reset through per-entry valid flags, so no
// clearing pass is needed. A finished result waits in the output register
// while the block returns to accepting requests.
// ----------------------------------------------------------------------------
module rating_tally_ranker
    import rtr_pkg::*;
#(
    parameter int NUM_CANDIDATES = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

`include "rating_tally_ranker_macros.svh"

    // The candidate field is five bits wide, so at most 32 entries are ever used.
    localparam int DEPTH = (NUM_CANDIDATES < 32) ? NUM_CANDIDATES : 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_WR,
        S_SC_RD,
        S_SC_CMP,
        S_LOAD
    } t_state;

    t_state r_state, n_state;

    // Totals memory, one read and one write port, registered read data.
    logic signed [TOTAL_W-1:0] r_mem [DEPTH];
    logic signed [TOTAL_W-1:0] r_rd_data;
    logic [IDX_W-1:0]          rd_addr;

    // Control and datapath registers.
    logic [DEPTH-1:0]          r_valid,   n_valid;
    logic                      r_rd_vld,  n_rd_vld;
    logic [CNT_W-1:0]          r_used,    n_used;
    logic [31:0]               r_ballots, n_ballots;
    logic [IDX_W-1:0]          r_cand,    n_cand;
    logic signed [15:0]        r_rating,  n_rating;
    logic [IDX_W-1:0]          r_k,       n_k;
    logic [CNT_W-1:0]          r_rank,    n_rank;
    logic [DEPTH-1:0]          r_emitted, n_emitted;
    logic                      r_have,    n_have;
    logic [IDX_W-1:0]          r_best,    n_best;
    logic signed [TOTAL_W-1:0] r_best_t,  n_best_t;
    logic                      r_out_vld, n_out_vld;
    t_out                      r_out,     n_out;

    logic                      in_acc;
    logic                      add_ok;
    logic signed [TOTAL_W-1:0] rd_val;
    logic signed [TOTAL_W:0]   sum;
    logic signed [TOTAL_W-1:0] sat_sum;
    logic                      k_last;
    logic                      rank_last;
    logic                      load_go;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_vld;
    assign o_data  = r_out;
    assign in_acc  = i_valid && o_ready;

    // Only a present rating for a candidate inside the table touches a total.
    assign add_ok = (i_data.cmd == CMD_ADD) && !i_data.rating_absent
                    && ({1'b0, i_data.candidate} < 6'(DEPTH));

    // While idle the memory is addressed straight from the request so that
    // the read of a candidate's total completes in the accept cycle.
    assign rd_addr = (r_state == S_IDLE) ? i_data.candidate[IDX_W-1:0] : r_k;

    // An entry never written since reset reads as zero.
    assign rd_val = r_rd_vld ? r_rd_data : '0;

    // The single shared adder: a 41-bit sum with saturation to 40 bits.
    assign sum     = {rd_val[TOTAL_W-1], rd_val}
                     + {{(TOTAL_W + 1 - 16){r_rating[15]}}, r_rating};
    assign sat_sum = (sum[TOTAL_W] != sum[TOTAL_W-1])
                     ? (sum[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX)
                     : sum[TOTAL_W-1:0];

    assign k_last    = (CNT_W'(r_k) == CNT_W'(r_used - 1'b1));
    assign rank_last = (CNT_W'(r_rank + 1'b1) == r_used);
    assign load_go   = (r_state == S_LOAD) && (!r_out_vld || i_ready);

    always_comb begin
        n_state   = r_state;
        n_valid   = r_valid;
        n_rd_vld  = r_valid[rd_addr];
        n_used    = r_used;
        n_ballots = r_ballots;
        n_cand    = r_cand;
        n_rating  = r_rating;
        n_k       = r_k;
        n_rank    = r_rank;
        n_emitted = r_emitted;
        n_have    = r_have;
        n_best    = r_best;
        n_best_t  = r_best_t;
        n_out_vld = r_out_vld;
        n_out     = r_out;

        if (r_out_vld && i_ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_data.cmd == CMD_ADD) begin
                        if (i_data.last_of_ballot) begin
                            n_ballots = r_ballots + 32'd1;
                        end
                        if (add_ok) begin
                            n_cand   = i_data.candidate[IDX_W-1:0];
                            n_rating = i_data.rating;
                            n_state  = S_ADD_WR;
                            if (CNT_W'(i_data.candidate[IDX_W-1:0]) >= r_used) begin
                                n_used = CNT_W'(i_data.candidate[IDX_W-1:0]) + 1'b1;
                            end
                        end
                    end else if (r_used != '0) begin
                        n_k       = '0;
                        n_rank    = '0;
                        n_emitted = '0;
                        n_have    = 1'b0;
                        n_state   = S_SC_RD;
                    end
                end
            end
            S_ADD_WR: begin
                n_valid[r_cand] = 1'b1;
                n_state         = S_IDLE;
            end
            S_SC_RD: begin
                n_state = S_SC_CMP;
            end
            S_SC_CMP: begin
                // Strictly greater wins, so equal totals keep the lower index.
                if (!r_emitted[r_k] && (!r_have || (rd_val > r_best_t))) begin
                    n_have   = 1'b1;
                    n_best   = r_k;
                    n_best_t = rd_val;
                end
                if (k_last) begin
                    n_state = S_LOAD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SC_RD;
                end
            end
            S_LOAD: begin
                if (load_go) begin
                    n_out_vld                  = 1'b1;
                    n_out.ranked_candidate     = 5'(r_best);
                    n_out.total                = r_best_t;
                    n_out.ballots              = r_ballots;
                    n_out.last_result          = rank_last;
                    n_emitted[r_best]          = 1'b1;
                    n_rank                     = CNT_W'(r_rank + 1'b1);
                    n_k                        = '0;
                    n_have                     = 1'b0;
                    n_state                    = rank_last ? S_IDLE : S_SC_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_rd_vld  <= 1'b0;
            r_used    <= '0;
            r_ballots <= '0;
            r_rank    <= '0;
            r_emitted <= '0;
            r_have    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_rd_vld  <= n_rd_vld;
            r_used    <= n_used;
            r_ballots <= n_ballots;
            r_rank    <= n_rank;
            r_emitted <= n_emitted;
            r_have    <= n_have;
            r_out_vld <= n_out_vld;
        end
        r_cand   <= n_cand;
        r_rating <= n_rating;
        r_k      <= n_k;
        r_best   <= n_best;
        r_best_t <= n_best_t;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ADD_WR) begin
            r_mem[r_cand] <= sat_sum;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    `RTR_ASSERT(a_used_in_range, r_used <= CNT_W'(DEPTH), "used count beyond table depth")
    `RTR_ASSERT(a_add_writes_next, in_acc && add_ok |=> r_state == S_ADD_WR, "add did not write back")
    `RTR_ASSERT(a_no_repeat, load_go |-> !r_emitted[r_best], "candidate reported twice")
    `RTR_ASSERT(a_rank_bound, r_state == S_LOAD |-> r_rank < r_used, "more results than used candidates")

endmodule

// ===== tb/rating_tally_ranker_checker.sv =====
// ----------------------------------------------------------------------------
// rating_tally_ranker_checker
// Tracks the rating totals seen on the request channel and checks each ranked
// report result against the totals expected at that point.
// ----------------------------------------------------------------------------
module rating_tally_ranker_checker
    import rtr_pkg::*;
#(
    parameter int NUM_CANDIDATES = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_ready,
    input  t_in  i_req,
    input  logic i_res_valid,
    input  logic i_res_ready,
    input  t_out i_res,
    output int   o_fail_count,
    output int   o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    logic signed [TOTAL_W-1:0] tally [NUM_CANDIDATES];
    int unsigned               used_cnt;
    logic [31:0]               ballot_cnt;
    t_out                      ranked_due [$];
    int                        fail_cnt = 0;

    // Only the first ten failures are printed; the rest are just counted.
    function automatic void note_failure(string what, t_out want, t_out got);
        if (fail_cnt < 10) begin
            $display("%t ns: %s: expected cand %0d total %0d ballots %0d last %0b,",
                     $realtime, what, want.ranked_candidate, want.total,
                     want.ballots, want.last_result);
            $display("    got cand %0d total %0d ballots %0d last %0b",
                     got.ranked_candidate, got.total, got.ballots, got.last_result);
        end
        fail_cnt++;
    endfunction

    function automatic void check_ranked(t_out got);
        t_out want;
        logic bad;
        if (ranked_due.size() == 0) begin
            note_failure("result with no report outstanding", '0, got);
            return;
        end
        want = ranked_due.pop_front();
        bad  = 1'b0;
        bad |= (got.ranked_candidate !== want.ranked_candidate);
        bad |= (got.total            !== want.total);
        bad |= (got.ballots          !== want.ballots);
        bad |= (got.last_result      !== want.last_result);
        if (bad) begin
            note_failure("ranked result mismatch", want, got);
        end
    endfunction

    // Apply an add request to the totals, or queue up the ranked readout of a
    // report: highest total first, the lower index first among equal totals.
    function automatic void tally_request(t_in r);
        logic signed [TOTAL_W:0] sum;
        int unsigned             n;
        int                      best;
        bit                      taken [NUM_CANDIDATES];
        t_out                    item;
        if (r.cmd == CMD_ADD) begin
            if (!r.rating_absent && int'(r.candidate) < NUM_CANDIDATES) begin
                sum = tally[r.candidate] + r.rating;
                if (sum > TOTAL_MAX) begin
                    tally[r.candidate] = TOTAL_MAX;
                end else if (sum < TOTAL_MIN) begin
                    tally[r.candidate] = TOTAL_MIN;
                end else begin
                    tally[r.candidate] = sum[TOTAL_W-1:0];
                end
                if (r.candidate >= used_cnt) begin
                    used_cnt = r.candidate + 1;
                end
            end
            if (r.last_of_ballot) begin
                ballot_cnt = ballot_cnt + 32'd1;
            end
        end else begin
            n = (used_cnt > NUM_CANDIDATES) ? NUM_CANDIDATES : used_cnt;
            if (n > 32) begin
                n = 32;
            end
            for (int c = 0; c < NUM_CANDIDATES; c++) begin
                taken[c] = 1'b0;
            end
            for (int unsigned rank = 0; rank < n; rank++) begin
                best = -1;
                for (int c = 0; c < n; c++) begin
                    if (!taken[c] && (best < 0 || tally[c] > tally[best])) begin
                        best = c;
                    end
                end
                taken[best]           = 1'b1;
                item.ranked_candidate = best[4:0];
                item.total            = tally[best];
                item.ballots          = ballot_cnt;
                item.last_result      = (rank + 1 == n);
                ranked_due.push_back(item);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CANDIDATES; c++) begin
                tally[c] = '0;
            end
            used_cnt   = 0;
            ballot_cnt = '0;
            ranked_due.delete();
        end else begin
            // A result leaving in this cycle belongs to an earlier report.
            if (i_res_valid && i_res_ready) begin
                check_ranked(i_res);
            end
            if (i_req_valid && i_req_ready) begin
                tally_request(i_req);
            end
        end
        o_fail_count = fail_cnt;
        o_pending    = ranked_due.size();
    end

endmodule

// ===== tb/rating_tally_ranker_test.sv =====
// ----------------------------------------------------------------------------
// rating_tally_ranker_test
// Drives add and report requests into the rating tally ranker and checks the
// ranked readouts through a side checker, with random gaps on both channels.
// ----------------------------------------------------------------------------
module rating_tally_ranker_test
    import rtr_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CANDIDATES = 32;

    // Number of random requests after the directed opening.
    localparam int RANDOM_REQUESTS = 180;

    // How long the result side holds off once, to back the block up.
    localparam int HOLD_CYCLES = 600;

    // Cycles allowed after the last expected result for anything stray.
    localparam int DRAIN_CYCLES = 200;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    t_in  req       = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    t_out res;

    int fail_count;
    int pending;

    // Each side keeps its own count of remaining gap-free requests, so that
    // stretches of back-to-back traffic alternate with random gaps.
    int  tx_calm     = 0;
    int  rx_calm     = 0;
    bit  no_gaps     = 1'b0;
    bit  hold_output = 1'b0;

    always #5 clk = ~clk;

    rating_tally_ranker #(
        .NUM_CANDIDATES(NUM_CANDIDATES)
    ) DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_valid(req_valid),
        .o_ready(req_ready),
        .i_data (req),
        .o_valid(res_valid),
        .i_ready(res_ready),
        .o_data (res)
    );

    rating_tally_ranker_checker #(
        .NUM_CANDIDATES(NUM_CANDIDATES)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .i_req_ready (req_ready),
        .i_req       (req),
        .i_res_valid (res_valid),
        .i_res_ready (res_ready),
        .i_res       (res),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Draws the number of idle cycles before the next transfer. Now and then
    // a run of 9 to 25 transfers goes through without any idle cycle.
    function automatic int pick_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm_left = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic t_in add_req(int cand, logic [15:0] rating, bit absent, bit last);
        t_in r;
        r.cmd            = CMD_ADD;
        r.candidate      = cand[4:0];
        r.rating         = rating;
        r.rating_absent  = absent;
        r.last_of_ballot = last;
        return r;
    endfunction

    // A report ignores every other field, so a noisy report fills them with
    // random values to show that they change nothing.
    function automatic t_in report_req(bit noisy);
        t_in r;
        r = noisy ? t_in'($bits(t_in)'($urandom)) : '0;
        r.cmd = CMD_REPORT;
        return r;
    endfunction

    // A random rating entry: mostly arbitrary values, but the range limits
    // and a few repeated small values show up often so that totals tie.
    function automatic t_in random_add(bit last);
        logic [15:0] rating;
        int          cand;
        case ($urandom_range(0, 7))
            0: rating = 16'h7FFF;
            1: rating = 16'h8000;
            2, 3: begin
                case ($urandom_range(0, 2))
                    0: rating = 16'h0000;
                    1: rating = 16'h0100;
                    default: rating = 16'hFF00;
                endcase
            end
            default: rating = 16'($urandom);
        endcase
        cand = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 31);
        return add_req(cand, rating, $urandom_range(0, 7) == 0, last);
    endfunction

    // Offers one request and returns at the falling edge after it was taken.
    // Called at a falling edge, so valid stays high between back-to-back
    // requests without being lowered in between.
    task automatic send_request(t_in r);
        int gap;
        gap = no_gaps ? 0 : pick_wait(tx_calm);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Result side: a random hold-off before each result, and one long hold
    // when the request side asks for it.
    initial begin
        int gap;
        wait (rst_n);
        @(negedge clk);
        forever begin
            if (hold_output) begin
                hold_output = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = pick_wait(rx_calm);
            end
            if (gap > 0) begin
                res_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid) begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    end

    // Stimulus and verdict.
    initial begin
        int  sent;
        int  entries;
        bit  broken;
        bit  pressed;

        sent    = 0;
        pressed = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A report straight after reset has no used candidate and yields
        // nothing at all.
        send_request(report_req(1'b0));

        // An absent rating still closes its ballot but leaves the total alone.
        send_request(add_req(0, 16'h0100, 1'b0, 1'b0));
        send_request(add_req(0, 16'h7FFF, 1'b1, 1'b1));
        send_request(report_req(1'b0));

        // Candidates 0 and 2 tie, and the most negative and most positive
        // ratings go in on candidates 1 and 3.
        send_request(add_req(2, 16'h0100, 1'b0, 1'b0));
        send_request(add_req(1, 16'h8000, 1'b0, 1'b1));
        send_request(add_req(3, 16'h7FFF, 1'b0, 1'b1));
        send_request(report_req(1'b0));

        // An absent rating on a high index must not widen the report.
        send_request(add_req(20, 16'h1234, 1'b1, 1'b1));
        send_request(report_req(1'b0));

        // The top index opens up the full candidate range.
        send_request(add_req(31, 16'hFFFF, 1'b0, 1'b0));
        send_request(add_req(30, 16'h5555, 1'b0, 1'b1));
        send_request(add_req(29, 16'hAAAA, 1'b0, 1'b0));
        send_request(report_req(1'b0));

        // Report with the other fields random: no ballot may be counted.
        send_request(report_req(1'b1));
        send_request(report_req(1'b0));

        // Random part: mostly whole ballots of one to six entries with the
        // last one marked, some broken ballots with random marks, and an
        // occasional report.
        while (sent < RANDOM_REQUESTS) begin
            if (!pressed && sent >= RANDOM_REQUESTS / 2) begin
                // Hold the result side off for a long stretch while requests
                // keep coming with no gaps, so the block backs up.
                pressed     = 1'b1;
                hold_output = 1'b1;
                no_gaps     = 1'b1;
                send_request(report_req(1'b1));
                for (int k = 0; k < 12; k++) begin
                    send_request(random_add(k % 3 == 2));
                end
                send_request(report_req(1'b1));
                no_gaps = 1'b0;
                sent += 14;
            end else if ($urandom_range(0, 11) == 0) begin
                send_request(report_req(1'b1));
                sent++;
            end else begin
                entries = $urandom_range(1, 6);
                broken  = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < entries; k++) begin
                    send_request(random_add(broken ? 1'($urandom_range(0, 1))
                                                   : (k == entries - 1)));
                    sent++;
                end
            end
        end

        // One last report reads out the final totals.
        send_request(report_req(1'b1));
        req_valid <= 1'b0;

        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("rating_tally_ranker_test: PASS");
        end else begin
            $display("rating_tally_ranker_test: FAIL");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #20ms;
        $display("rating_tally_ranker_test: FAIL");
        $finish;
    end

endmodule
